// ===== design/tmis_pkg.sv =====
// Shared types and codes for the tiled matmul instruction sequencer.
// No dependencies; used by every module of the block.
package tmis_pkg;

  typedef struct packed {
    logic        func;
    logic [15:0] tiles_m;
    logic [15:0] tiles_n;
    logic [15:0] tiles_k;
    logic        random_b_mode;
  } in_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] address;
    logic [15:0] tile_width;
    logic [15:0] tile_height;
    logic [15:0] row_stride;
    logic [3:0]  elem_bytes;
    logic [1:0]  tile_reg;
    logic        last;
    logic        error;
  } out_t;

  // instruction opcodes
  localparam logic [2:0] OPC_STRTRNG = 3'd0;
  localparam logic [2:0] OPC_TMOV    = 3'd1;
  localparam logic [2:0] OPC_TMULAC  = 3'd2;
  localparam logic [2:0] OPC_STORE   = 3'd3;
  localparam logic [2:0] OPC_STPRNG  = 3'd4;
  localparam logic [2:0] OPC_NONE    = 3'd5;

  // tile registers
  localparam logic [1:0] TR_A = 2'd0;
  localparam logic [1:0] TR_B = 2'd1;
  localparam logic [1:0] TR_C = 2'd2;

  // register indexes (8-byte spacing)
  localparam logic [2:0] REG_A_BASE = 3'd0;
  localparam logic [2:0] REG_B_BASE = 3'd1;
  localparam logic [2:0] REG_C_BASE = 3'd2;
  localparam logic [2:0] REG_DIM_M  = 3'd3;
  localparam logic [2:0] REG_DIM_N  = 3'd4;
  localparam logic [2:0] REG_DIM_K  = 3'd5;
  localparam logic [2:0] REG_EB_A   = 3'd6;
  localparam logic [2:0] REG_EB_B   = 3'd7;

  // program phase
  typedef enum logic [2:0] {
    PH_STRT = 3'd0,
    PH_LDC  = 3'd1,
    PH_LDA  = 3'd2,
    PH_LDB  = 3'd3,
    PH_MAC  = 3'd4,
    PH_STC  = 3'd5,
    PH_STP  = 3'd6
  } phase_t;

  // jobs of the shared iterative arithmetic unit
  typedef enum logic [2:0] {
    AOP_DIVM = 3'd0,
    AOP_DIVN = 3'd1,
    AOP_DIVK = 3'd2,
    AOP_MUL1 = 3'd3,
    AOP_MUL2 = 3'd4
  } arith_op_t;

  typedef struct packed {
    logic      load;
    logic      start;
    arith_op_t op;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic bad;
    logic needs_addr;
    logic done;
  } sts_t;

endpackage

// ===== design/tiled_matmul_instruction_sequencer_top.sv =====
// One word in at a time. A start word with good tile counts runs three divisions
// on the shared unit; a load/store with a computed address runs two shift-add
// multiplies; other words use neither. Result goes to an output register; a
// stalled result holds off the commit of the next word. Synchronous active-high
// reset clears control, program state and registers (bases 0, dims 1, element
// sizes 1).
module tiled_matmul_instruction_sequencer_top #(
  parameter int ADDR_WIDTH = 64,
  parameter int DIM_WIDTH  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tmis_pkg::in_t  in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output tmis_pkg::out_t out_word,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);

  logic [ADDR_WIDTH-1:0] a_base, b_base, c_base;
  logic [DIM_WIDTH-1:0]  dim_m, dim_n, dim_k;
  logic [3:0]            eb_a, eb_b;
  tmis_pkg::cmd_t        cmd;
  tmis_pkg::sts_t        sts;
  tmis_pkg::out_t        res;
  logic                  out_free;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_base <= '0;
      b_base <= '0;
      c_base <= '0;
      dim_m  <= DIM_WIDTH'(1);
      dim_n  <= DIM_WIDTH'(1);
      dim_k  <= DIM_WIDTH'(1);
      eb_a   <= 4'd1;
      eb_b   <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        tmis_pkg::REG_A_BASE: a_base <= pwdata[ADDR_WIDTH-1:0];
        tmis_pkg::REG_B_BASE: b_base <= pwdata[ADDR_WIDTH-1:0];
        tmis_pkg::REG_C_BASE: c_base <= pwdata[ADDR_WIDTH-1:0];
        tmis_pkg::REG_DIM_M:  dim_m  <= pwdata[DIM_WIDTH-1:0];
        tmis_pkg::REG_DIM_N:  dim_n  <= pwdata[DIM_WIDTH-1:0];
        tmis_pkg::REG_DIM_K:  dim_k  <= pwdata[DIM_WIDTH-1:0];
        tmis_pkg::REG_EB_A:   eb_a   <= pwdata[3:0];
        tmis_pkg::REG_EB_B:   eb_b   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      tmis_pkg::REG_A_BASE: prdata = 64'(a_base);
      tmis_pkg::REG_B_BASE: prdata = 64'(b_base);
      tmis_pkg::REG_C_BASE: prdata = 64'(c_base);
      tmis_pkg::REG_DIM_M:  prdata = 64'(dim_m);
      tmis_pkg::REG_DIM_N:  prdata = 64'(dim_n);
      tmis_pkg::REG_DIM_K:  prdata = 64'(dim_k);
      tmis_pkg::REG_EB_A:   prdata = 64'(eb_a);
      tmis_pkg::REG_EB_B:   prdata = 64'(eb_b);
      default:              prdata = '0;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word <= res;
    end
  end

  tmis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmis_dpath #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .DIM_WIDTH  (DIM_WIDTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .item   (in_word),
    .a_base (a_base),
    .b_base (b_base),
    .c_base (c_base),
    .dim_m  (dim_m),
    .dim_n  (dim_n),
    .dim_k  (dim_k),
    .eb_a   (eb_a),
    .eb_b   (eb_b),
    .res    (res)
  );

endmodule

// ===== design/tmis_ctrl.sv =====
// Sequencer controller: handshake, job ordering for the arithmetic unit, commit.
// Depends on tmis_pkg.
module tmis_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_free,
  input  tmis_pkg::sts_t  sts,
  output tmis_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEC  = 8'b0000_0010,
    S_DIVM = 8'b0000_0100,
    S_DIVN = 8'b0000_1000,
    S_DIVK = 8'b0001_0000,
    S_MUL1 = 8'b0010_0000,
    S_MUL2 = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = tmis_pkg::AOP_MUL1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_start && !sts.bad) begin
          cmd.start  = 1'b1;
          cmd.op     = tmis_pkg::AOP_DIVM;
          state_next = S_DIVM;
        end else if (sts.needs_addr) begin
          cmd.start  = 1'b1;
          cmd.op     = tmis_pkg::AOP_MUL1;
          state_next = S_MUL1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIVM: begin
        if (sts.done) begin
          cmd.start  = 1'b1;
          cmd.op     = tmis_pkg::AOP_DIVN;
          state_next = S_DIVN;
        end
      end
      S_DIVN: begin
        if (sts.done) begin
          cmd.start  = 1'b1;
          cmd.op     = tmis_pkg::AOP_DIVK;
          state_next = S_DIVK;
        end
      end
      S_DIVK: begin
        if (sts.done) begin
          state_next = S_DONE;
        end
      end
      S_MUL1: begin
        if (sts.done) begin
          cmd.start  = 1'b1;
          cmd.op     = tmis_pkg::AOP_MUL2;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        if (sts.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== design/tmis_dpath.sv =====
// Sequencer datapath: program state, tile offsets, shared shift-add multiplier
// and restoring divider, result word assembly. Depends on tmis_pkg.
module tmis_dpath #(
  parameter int ADDR_WIDTH = 64,
  parameter int DIM_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tmis_pkg::cmd_t        cmd,
  output tmis_pkg::sts_t        sts,
  input  tmis_pkg::in_t         item,
  input  logic [ADDR_WIDTH-1:0] a_base,
  input  logic [ADDR_WIDTH-1:0] b_base,
  input  logic [ADDR_WIDTH-1:0] c_base,
  input  logic [DIM_WIDTH-1:0]  dim_m,
  input  logic [DIM_WIDTH-1:0]  dim_n,
  input  logic [DIM_WIDTH-1:0]  dim_k,
  input  logic [3:0]            eb_a,
  input  logic [3:0]            eb_b,
  output tmis_pkg::out_t        res
);

  localparam int DW = DIM_WIDTH;
  localparam int OW = 2 * DIM_WIDTH;
  localparam int MW = (ADDR_WIDTH > OW) ? ADDR_WIDTH : OW;
  localparam int CW = $clog2(DIM_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIM_WIDTH - 1);

  function automatic logic [DW-1:0] clip(input logic [DW-1:0] size,
                                         input logic [DW-1:0] dim,
                                         input logic [OW-1:0] off);
    logic [OW-1:0] rem;
    rem = OW'(dim) - off;
    if (off >= OW'(dim)) begin
      clip = '0;
    end else if (rem < OW'(size)) begin
      clip = rem[DW-1:0];
    end else begin
      clip = size;
    end
  endfunction

  tmis_pkg::in_t    item_r;
  tmis_pkg::phase_t phase;
  logic             running;
  logic             rnd;
  logic [DW-1:0]    tsm, tsn, tsk;
  logic [OW-1:0]    off_r, off_c, off_k;

  // arithmetic unit
  logic                busy, done;
  logic [CW-1:0]       cnt;
  tmis_pkg::arith_op_t op_r;
  logic [DW-1:0]       dv_rem, dv_q, dv_d;
  logic [DW:0]         dv_sh;
  logic [MW-1:0]       mc, acc;
  logic [DW-1:0]       mp;

  logic [DW-1:0]         tm, tn, tk;
  logic [3:0]            ec;
  logic [DW-1:0]         cw, ch, aw;
  logic [OW-1:0]         off_r_inc, off_c_inc, off_k_inc;
  logic                  col_wrap, row_end;
  logic [OW-1:0]         mx, my;
  logic [DW-1:0]         md;
  logic [3:0]            me;
  logic [ADDR_WIDTH-1:0] mbase, maddr;

  assign tm = DW'(item_r.tiles_m);
  assign tn = DW'(item_r.tiles_n);
  assign tk = DW'(item_r.tiles_k);
  assign ec = (eb_a > eb_b) ? eb_a : eb_b;

  assign cw = clip(tsn, dim_n, off_c);
  assign ch = clip(tsm, dim_m, off_r);
  assign aw = clip(tsk, dim_k, off_k);

  assign off_r_inc = off_r + OW'(tsm);
  assign off_c_inc = off_c + OW'(tsn);
  assign off_k_inc = off_k + OW'(tsk);
  assign col_wrap  = off_c_inc >= OW'(dim_n);
  assign row_end   = off_r_inc >= OW'(dim_m);

  assign sts.is_start   = !item_r.func;
  assign sts.bad        = (tm == '0) || (tn == '0) || (tk == '0) ||
                          (tm > dim_m) || (tn > dim_n) || (tk > dim_k);
  assign sts.needs_addr = item_r.func && running &&
                          ((phase == tmis_pkg::PH_LDC) || (phase == tmis_pkg::PH_STC) ||
                           (phase == tmis_pkg::PH_LDA) ||
                           ((phase == tmis_pkg::PH_LDB) && !rnd));
  assign sts.done       = done;

  // address = base + (x * d + y) * e, operands by phase
  always_comb begin
    case (phase)
      tmis_pkg::PH_LDA: begin
        mx = off_r; md = dim_k; my = off_k; me = eb_a; mbase = a_base;
      end
      tmis_pkg::PH_LDB: begin
        mx = off_k; md = dim_n; my = off_c; me = eb_b; mbase = b_base;
      end
      default: begin
        mx = off_r; md = dim_n; my = off_c; me = ec; mbase = c_base;
      end
    endcase
  end

  assign maddr = mbase + acc[ADDR_WIDTH-1:0];
  assign dv_sh = {dv_rem, dv_q[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.start) begin
      op_r   <= cmd.op;
      cnt    <= CNT_LAST;
      dv_rem <= '0;
      acc    <= '0;
      case (cmd.op)
        tmis_pkg::AOP_DIVM: begin dv_q <= dim_m; dv_d <= tm; end
        tmis_pkg::AOP_DIVN: begin dv_q <= dim_n; dv_d <= tn; end
        tmis_pkg::AOP_DIVK: begin dv_q <= dim_k; dv_d <= tk; end
        tmis_pkg::AOP_MUL1: begin mc <= MW'(mx); mp <= md; end
        tmis_pkg::AOP_MUL2: begin mc <= acc + MW'(my); mp <= DW'(me); end
        default: ;
      endcase
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (dv_sh >= {1'b0, dv_d}) begin
        dv_rem <= DW'(dv_sh - {1'b0, dv_d});
        dv_q   <= {dv_q[DW-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh[DW-1:0];
        dv_q   <= {dv_q[DW-2:0], 1'b0};
      end
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= {mc[MW-2:0], 1'b0};
      mp <= {1'b0, mp[DW-1:1]};
    end
    if (done) begin
      case (op_r)
        tmis_pkg::AOP_DIVM: tsm <= dv_q;
        tmis_pkg::AOP_DIVN: tsn <= dv_q;
        tmis_pkg::AOP_DIVK: tsk <= dv_q;
        default: ;
      endcase
    end
  end

  // program state, advanced once per delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rnd     <= 1'b0;
      phase   <= tmis_pkg::PH_STRT;
      off_r   <= '0;
      off_c   <= '0;
      off_k   <= '0;
    end else if (cmd.commit) begin
      if (sts.is_start) begin
        if (sts.bad) begin
          running <= 1'b0;
          phase   <= tmis_pkg::PH_STRT;
        end else begin
          running <= 1'b1;
          rnd     <= item_r.random_b_mode;
          phase   <= item_r.random_b_mode ? tmis_pkg::PH_STRT : tmis_pkg::PH_LDC;
          off_r   <= '0;
          off_c   <= '0;
          off_k   <= '0;
        end
      end else if (running) begin
        case (phase)
          tmis_pkg::PH_STRT: phase <= tmis_pkg::PH_LDC;
          tmis_pkg::PH_LDC: begin
            off_k <= '0;
            phase <= tmis_pkg::PH_LDA;
          end
          tmis_pkg::PH_LDA: phase <= tmis_pkg::PH_LDB;
          tmis_pkg::PH_LDB: phase <= tmis_pkg::PH_MAC;
          tmis_pkg::PH_MAC: begin
            off_k <= off_k_inc;
            phase <= (off_k_inc >= OW'(dim_k)) ? tmis_pkg::PH_STC : tmis_pkg::PH_LDA;
          end
          tmis_pkg::PH_STC: begin
            if (col_wrap) begin
              off_c <= '0;
              off_r <= off_r_inc;
              if (row_end) begin
                if (rnd) begin
                  phase <= tmis_pkg::PH_STP;
                end else begin
                  running <= 1'b0;
                  phase   <= tmis_pkg::PH_STRT;
                end
              end else begin
                phase <= tmis_pkg::PH_LDC;
              end
            end else begin
              off_c <= off_c_inc;
              phase <= tmis_pkg::PH_LDC;
            end
          end
          default: begin
            running <= 1'b0;
            phase   <= tmis_pkg::PH_STRT;
          end
        endcase
      end
    end
  end

  always_comb begin
    res        = '0;
    res.opcode = tmis_pkg::OPC_NONE;
    if (sts.is_start) begin
      res.error = sts.bad;
    end else if (!running) begin
      res.error = 1'b1;
    end else begin
      case (phase)
        tmis_pkg::PH_STRT: begin
          res.opcode  = tmis_pkg::OPC_STRTRNG;
          res.address = 64'(b_base);
        end
        tmis_pkg::PH_LDC, tmis_pkg::PH_STC: begin
          res.opcode      = (phase == tmis_pkg::PH_LDC) ? tmis_pkg::OPC_TMOV
                                                        : tmis_pkg::OPC_STORE;
          res.address     = 64'(maddr);
          res.tile_width  = 16'(cw);
          res.tile_height = 16'(ch);
          res.row_stride  = 16'(dim_n);
          res.elem_bytes  = ec;
          res.tile_reg    = tmis_pkg::TR_C;
          res.last        = (phase == tmis_pkg::PH_STC) && col_wrap && row_end && !rnd;
        end
        tmis_pkg::PH_LDA: begin
          res.opcode      = tmis_pkg::OPC_TMOV;
          res.address     = 64'(maddr);
          res.tile_width  = 16'(aw);
          res.tile_height = 16'(ch);
          res.row_stride  = 16'(dim_k);
          res.elem_bytes  = eb_a;
          res.tile_reg    = tmis_pkg::TR_A;
        end
        tmis_pkg::PH_LDB: begin
          res.opcode      = tmis_pkg::OPC_TMOV;
          res.address     = rnd ? 64'(b_base) : 64'(maddr);
          res.tile_width  = 16'(cw);
          res.tile_height = 16'(aw);
          res.row_stride  = 16'(dim_n);
          res.elem_bytes  = eb_b;
          res.tile_reg    = tmis_pkg::TR_B;
        end
        tmis_pkg::PH_MAC: res.opcode = tmis_pkg::OPC_TMULAC;
        default: begin
          res.opcode = tmis_pkg::OPC_STPRNG;
          res.last   = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== design/tmis_checker.sv =====
// Port-level checks for the sequencer top level, attached by bind.
// Depends on tmis_pkg.
module tmis_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input tmis_pkg::out_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new word taken while busy");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.last |->
      (out_word.opcode == tmis_pkg::OPC_STORE) || (out_word.opcode == tmis_pkg::OPC_STPRNG))
    else $error("last flag on wrong instruction");

  a_error_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.error |->
      (out_word.opcode == tmis_pkg::OPC_NONE) && !out_word.last)
    else $error("error word carries an instruction");

  a_mac_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.opcode == tmis_pkg::OPC_TMULAC) |->
      (out_word.elem_bytes == 4'd0) && (out_word.address == 64'd0))
    else $error("multiply word has memory fields");

endmodule

bind tiled_matmul_instruction_sequencer_top tmis_checker u_tmis_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
